// File: hw/rtl/lzft_pkg.sv
// Shared types and constants for the LZ77 flag-token stream decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package lzft_pkg;

  // Default sizes handed to the top level.
  localparam int unsigned DEF_WINDOW_DEPTH = 4096;
  localparam int unsigned DEF_MAX_COPY     = 63;

  // Command fields are sized for the widest legal configuration.
  localparam int unsigned OFF_W = 17;
  localparam int unsigned LEN_W = 6;

  // Depth of the command queue between parser and executor.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_FLAG = 3'd2,
    PH_LIT  = 3'd3,
    PH_OFF  = 3'd4,
    PH_LEN  = 3'd5,
    PH_NEXT = 3'd6
  } phase_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_DATA    = 3'd0,
    ST_BAD_HDR = 3'd1,
    ST_OFF_OUT = 3'd2,
    ST_OFF_WIN = 3'd3,
    ST_LEN_BIG = 3'd4,
    ST_TRUNC   = 3'd5
  } status_e;

  // Kinds of work the parser hands to the executor.
  typedef enum logic [1:0] {
    CMD_LIT  = 2'd0,
    CMD_COPY = 2'd1,
    CMD_ERR  = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [7:0]        data;
    status_e           status;
    logic [OFF_W-1:0]  off;
    logic [LEN_W-1:0]  len;
  } cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/lzft_front.sv
// Stream parser: header, flag bytes and token fields, with all match checks.
// Depends on lzft_pkg; pushes one command per result-producing beat.
`default_nettype none

module lzft_front import lzft_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int unsigned MAX_COPY     = DEF_MAX_COPY
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       end_of_stream_i,
  input  wire logic       full_i,
  output logic            push_o,
  output cmd_t            cmd_o
);

  phase_e      phase_q, phase_d;
  logic [2:0]  lw_q, lw_d;
  logic        lw_bad_q, lw_bad_d;
  logic [2:0]  ow_q, ow_d;
  logic [7:0]  flag_q, flag_d;
  logic [2:0]  tok_q, tok_d;
  logic [1:0]  fbc_q, fbc_d;
  logic [31:0] off_acc_q, off_acc_d;
  logic [31:0] len_acc_q, len_acc_d;
  logic [31:0] prod_q, prod_d;
  logic        halted_q, halted_d;

  logic        accept;
  logic        hdr1_bad;
  logic        off_zero, off_out, off_win, len_big;
  logic        tok_last;
  logic [2:0]  tok_inc;
  phase_e      tok_phase;
  logic        fbc_done_off, fbc_done_len;
  logic [32:0] sum_lit, sum_copy;
  logic [31:0] prod_lit, prod_copy;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Classification of the current byte and token.
  assign hdr1_bad = lw_bad_q || (in_byte_i == 8'd0) || (in_byte_i > 8'd4);
  assign off_zero = (off_acc_q == 32'd0);
  assign off_out  = (off_acc_q > prod_q);
  assign off_win  = (off_acc_q > 32'(WINDOW_DEPTH));
  assign len_big  = (len_acc_q > 32'(MAX_COPY));

  // Token sequencing within a flag group.
  assign tok_last  = (tok_q == 3'd7);
  assign tok_inc   = tok_q + 3'd1;
  assign tok_phase = flag_q[tok_inc] ? PH_LIT : PH_OFF;

  assign fbc_done_off = (({1'b0, fbc_q} + 3'd1) >= ow_q);
  assign fbc_done_len = (({1'b0, fbc_q} + 3'd1) >= lw_q);

  // Saturating count of bytes produced in this stream.
  assign sum_lit   = {1'b0, prod_q} + 33'd1;
  assign sum_copy  = {1'b0, prod_q} + 33'(len_acc_q[LEN_W-1:0]) + 33'd1;
  assign prod_lit  = sum_lit[32] ? 32'hFFFF_FFFF : sum_lit[31:0];
  assign prod_copy = sum_copy[32] ? 32'hFFFF_FFFF : sum_copy[31:0];

  // Next state.
  always_comb begin
    phase_d   = phase_q;
    lw_d      = lw_q;
    lw_bad_d  = lw_bad_q;
    ow_d      = ow_q;
    flag_d    = flag_q;
    tok_d     = tok_q;
    fbc_d     = fbc_q;
    off_acc_d = off_acc_q;
    len_acc_d = len_acc_q;
    prod_d    = prod_q;
    halted_d  = halted_q;
    if (accept && !halted_q) begin
      case (phase_q)
        PH_HDR0: begin
          lw_d     = in_byte_i[2:0];
          lw_bad_d = (in_byte_i == 8'd0) || (in_byte_i > 8'd4);
          phase_d  = PH_HDR1;
          if (end_of_stream_i) begin
            halted_d = 1'b1;
          end
        end
        PH_HDR1: begin
          if (hdr1_bad) begin
            halted_d = 1'b1;
          end else begin
            ow_d    = in_byte_i[2:0];
            phase_d = PH_FLAG;
          end
        end
        PH_FLAG: begin
          flag_d    = in_byte_i;
          tok_d     = 3'd0;
          fbc_d     = 2'd0;
          off_acc_d = 32'd0;
          len_acc_d = 32'd0;
          phase_d   = in_byte_i[0] ? PH_LIT : PH_OFF;
        end
        PH_LIT: begin
          prod_d    = prod_lit;
          tok_d     = tok_inc;
          fbc_d     = 2'd0;
          off_acc_d = 32'd0;
          len_acc_d = 32'd0;
          phase_d   = tok_last ? PH_FLAG : tok_phase;
        end
        PH_OFF: begin
          off_acc_d[8*fbc_q +: 8] = in_byte_i;
          if (fbc_done_off) begin
            fbc_d   = 2'd0;
            phase_d = PH_LEN;
          end else begin
            fbc_d = fbc_q + 2'd1;
          end
        end
        PH_LEN: begin
          len_acc_d[8*fbc_q +: 8] = in_byte_i;
          if (fbc_done_len) begin
            fbc_d   = 2'd0;
            phase_d = PH_NEXT;
          end else begin
            fbc_d = fbc_q + 2'd1;
          end
        end
        PH_NEXT: begin
          if (off_zero) begin
            tok_d     = 3'd0;
            fbc_d     = 2'd0;
            len_acc_d = 32'd0;
            phase_d   = PH_FLAG;
          end else if (off_out || off_win || len_big) begin
            halted_d = 1'b1;
          end else begin
            prod_d    = prod_copy;
            tok_d     = tok_inc;
            fbc_d     = 2'd0;
            off_acc_d = 32'd0;
            len_acc_d = 32'd0;
            phase_d   = tok_last ? PH_FLAG : tok_phase;
          end
        end
        default: begin
          phase_d = PH_HDR0;
        end
      endcase
    end
    // The final beat of a stream returns the parser to its reset state.
    if (accept && end_of_stream_i) begin
      phase_d   = PH_HDR0;
      lw_d      = 3'd0;
      lw_bad_d  = 1'b0;
      ow_d      = 3'd0;
      flag_d    = 8'd0;
      tok_d     = 3'd0;
      fbc_d     = 2'd0;
      off_acc_d = 32'd0;
      len_acc_d = 32'd0;
      prod_d    = 32'd0;
      halted_d  = 1'b0;
    end
  end

  // Command generation.
  always_comb begin
    push_o        = 1'b0;
    cmd_o.kind    = CMD_LIT;
    cmd_o.data    = in_byte_i;
    cmd_o.status  = ST_DATA;
    cmd_o.off     = off_acc_q[OFF_W-1:0];
    cmd_o.len     = len_acc_q[LEN_W-1:0];
    if (accept && !halted_q) begin
      case (phase_q)
        PH_HDR0: begin
          if (end_of_stream_i) begin
            push_o       = 1'b1;
            cmd_o.kind   = CMD_ERR;
            cmd_o.status = ST_TRUNC;
          end
        end
        PH_HDR1: begin
          if (hdr1_bad) begin
            push_o       = 1'b1;
            cmd_o.kind   = CMD_ERR;
            cmd_o.status = ST_BAD_HDR;
          end
        end
        PH_LIT: begin
          push_o = 1'b1;
        end
        PH_NEXT: begin
          if (off_zero) begin
            push_o = 1'b0;
          end else if (off_out) begin
            push_o       = 1'b1;
            cmd_o.kind   = CMD_ERR;
            cmd_o.status = ST_OFF_OUT;
          end else if (off_win) begin
            push_o       = 1'b1;
            cmd_o.kind   = CMD_ERR;
            cmd_o.status = ST_OFF_WIN;
          end else if (len_big) begin
            push_o       = 1'b1;
            cmd_o.kind   = CMD_ERR;
            cmd_o.status = ST_LEN_BIG;
          end else begin
            push_o     = 1'b1;
            cmd_o.kind = CMD_COPY;
          end
        end
        default: begin
          push_o = 1'b0;
        end
      endcase
    end
  end

  // Parser registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR0;
      lw_q      <= 3'd0;
      lw_bad_q  <= 1'b0;
      ow_q      <= 3'd0;
      flag_q    <= 8'd0;
      tok_q     <= 3'd0;
      fbc_q     <= 2'd0;
      off_acc_q <= 32'd0;
      len_acc_q <= 32'd0;
      prod_q    <= 32'd0;
      halted_q  <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      lw_q      <= lw_d;
      lw_bad_q  <= lw_bad_d;
      ow_q      <= ow_d;
      flag_q    <= flag_d;
      tok_q     <= tok_d;
      fbc_q     <= fbc_d;
      off_acc_q <= off_acc_d;
      len_acc_q <= len_acc_d;
      prod_q    <= prod_d;
      halted_q  <= halted_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lzft_queue.sv
// Short command queue that decouples the parser from the executor.
// Depends on lzft_pkg for the command type and depth.
`default_nettype none

module lzft_queue import lzft_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  input  wire logic pop_i,
  output cmd_t      cmd_o,
  output logic      empty_o,
  output logic      full_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            ent_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign cmd_o   = ent_q[rd_ptr_q];

  // Pointer and fill-count update with wrap at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lzft_back.sv
// Command executor: history window, match copy engine and output register.
// Depends on lzft_pkg for the command type and status codes.
`default_nettype none

module lzft_back import lzft_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int unsigned MAX_COPY     = DEF_MAX_COPY
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cmd_valid_i,
  input  wire cmd_t       cmd_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic [2:0]      status_o,
  output logic            last_of_run_o
);

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);
  localparam int unsigned CW = $clog2(MAX_COPY + 1);

  logic [7:0]    mem [WINDOW_DEPTH];
  logic [7:0]    rdata_q;

  logic          busy_q, busy_d;
  logic          pend_q, pend_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] src_q, src_d;
  logic [AW-1:0] raddr_q, raddr_d;
  logic [AW-1:0] wp_q, wp_d;
  logic [7:0]    next_q, next_d;

  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q, out_byte_d;
  status_e       status_q, status_d;
  logic          last_q, last_d;

  logic          load;
  logic          issue;
  logic          we;
  logic [7:0]    wdata;
  logic [AW-1:0] raddr;
  logic [AW:0]   src_sum, src_start;

  assign load = !out_valid_q || out_ready_i;

  // Start address of a match: write pointer minus offset, modulo the window.
  assign src_sum   = {1'b0, wp_q} + (AW+1)'(WINDOW_DEPTH) - cmd_i.off[AW:0];
  assign src_start = (src_sum >= (AW+1)'(WINDOW_DEPTH)) ?
                     src_sum - (AW+1)'(WINDOW_DEPTH) : src_sum;

  // Copy sequencing and result selection.
  always_comb begin
    busy_d      = busy_q;
    cnt_d       = cnt_q;
    src_d       = src_q;
    next_d      = next_q;
    pop_o       = 1'b0;
    issue       = 1'b0;
    we          = 1'b0;
    wdata       = rdata_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    status_d    = status_q;
    last_d      = last_q;
    if (busy_q) begin
      if (pend_q) begin
        if (load) begin
          we          = 1'b1;
          wdata       = rdata_q;
          out_valid_d = 1'b1;
          out_byte_d  = rdata_q;
          status_d    = ST_DATA;
          last_d      = 1'b0;
        end
      end else if (cnt_q == '0) begin
        if (load) begin
          we          = 1'b1;
          wdata       = next_q;
          out_valid_d = 1'b1;
          out_byte_d  = next_q;
          status_d    = ST_DATA;
          last_d      = 1'b1;
          busy_d      = 1'b0;
        end
      end
      issue = (cnt_q != '0) && (!pend_q || load);
    end else if (cmd_valid_i) begin
      case (cmd_i.kind)
        CMD_LIT: begin
          if (load) begin
            pop_o       = 1'b1;
            we          = 1'b1;
            wdata       = cmd_i.data;
            out_valid_d = 1'b1;
            out_byte_d  = cmd_i.data;
            status_d    = ST_DATA;
            last_d      = 1'b1;
          end
        end
        CMD_COPY: begin
          pop_o  = 1'b1;
          busy_d = 1'b1;
          cnt_d  = cmd_i.len[CW-1:0];
          src_d  = src_start[AW-1:0];
          next_d = cmd_i.data;
        end
        default: begin
          if (load) begin
            pop_o       = 1'b1;
            out_valid_d = 1'b1;
            out_byte_d  = 8'd0;
            status_d    = cmd_i.status;
            last_d      = 1'b1;
          end
        end
      endcase
    end
    if (issue) begin
      cnt_d = cnt_q - 1'b1;
      src_d = (src_q == AW'(WINDOW_DEPTH - 1)) ? '0 : src_q + 1'b1;
    end
  end

  // Read address: a new copy source, or the pending one again while stalled.
  assign raddr   = issue ? src_q : raddr_q;
  assign raddr_d = raddr;
  assign pend_d  = issue || (pend_q && !load);
  assign wp_d    = !we ? wp_q :
                   (wp_q == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_q + 1'b1;

  // History window with a write-to-read bypass for offset-one copies.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wp_q] <= wdata;
    end
    rdata_q <= (we && (wp_q == raddr)) ? wdata : mem[raddr];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pend_q      <= 1'b0;
      cnt_q       <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      wp_q        <= wp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    src_q      <= src_d;
    raddr_q    <= raddr_d;
    next_q     <= next_d;
    out_byte_q <= out_byte_d;
    status_q   <= status_d;
    last_q     <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign status_o      = status_q;
  assign last_of_run_o = last_q;

`ifndef SYNTHESIS
  // A pending history read only exists inside a match copy.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pend_q |-> busy_q)
    else $error("history read pending outside a copy");

  // A copy never runs longer than the length limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q <= CW'(MAX_COPY)))
    else $error("copy count above limit");

  // A history write happens only while a data result is loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |=> (out_valid_q && (status_q == ST_DATA)))
    else $error("history write without a data result");

  // Error results always close the run of their input byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q != ST_DATA)) |-> last_q)
    else $error("error result not marked last");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/lz77_flag_token_decompressor.sv
// LZ77 flag-token stream decoder: parser, command queue and copy executor.
// A literal passes through the command queue and then the output register on its way out.
// Throughput: one input beat per cycle while the two-entry command queue has room;
// a match holds the executor while it runs: a start step, one history read per byte
// of its length, whose data is registered before it goes out, then the next byte.
// Reset clears all control state at once; the history memory is not cleared.
// Depends on lzft_pkg, lzft_front, lzft_queue and lzft_back.
`default_nettype none

module lz77_flag_token_decompressor import lzft_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int unsigned MAX_COPY     = DEF_MAX_COPY
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       end_of_stream_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic [2:0]      status_o,
  output logic            last_of_run_o
);

  logic push;
  cmd_t push_cmd;
  logic pop;
  cmd_t head_cmd;
  logic q_empty;
  logic q_full;

  // Parser front end.
  lzft_front #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .MAX_COPY     (MAX_COPY)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_byte_i       (in_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .full_i          (q_full),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  // Command queue.
  lzft_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // Executor back end.
  lzft_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .MAX_COPY     (MAX_COPY)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (!q_empty),
    .cmd_i         (head_cmd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .status_o      (status_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

`default_nettype wire
